[rtl/core/assert_macros.svh]
// Assertion helpers used by the scheduler datapath.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Property must hold at every clock edge outside reset.
`define ASSERT_HOLDS(label, clk, rst_n, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("scheduler assertion failed");

// Consequent must hold in the same cycle as the antecedent.
`define ASSERT_IMPLY(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("scheduler assertion failed");

// Consequent must hold in the cycle after the antecedent.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("scheduler assertion failed");

`endif

[rtl/core/mcrqs_pkg.sv]
package mcrqs_pkg;

    // Field widths of the channels
    localparam int OP_W      = 3;
    localparam int CPU_IDX_W = 4;
    localparam int PID_W     = 6;
    localparam int PRI_W     = 8;
    localparam int SLICE_W   = 16;
    localparam int MODE_W    = 2;
    localparam int ACT_W     = 5;
    localparam int KIND_W    = 2;
    localparam int STATE_W   = 2;
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 16;
    localparam int ENTRY_W   = PID_W + PRI_W;

    typedef logic [OP_W-1:0]    op_t;
    typedef logic [KIND_W-1:0]  kind_t;
    typedef logic [STATE_W-1:0] pstate_t;
    typedef logic [MODE_W-1:0]  mode_t;
    typedef logic [CFG_IDX_W-1:0] reg_idx_t;

    // Event operations
    localparam op_t OP_PREEMPT   = 3'd0;
    localparam op_t OP_YIELD     = 3'd1;
    localparam op_t OP_TERMINATE = 3'd2;
    localparam op_t OP_IDLE      = 3'd3;
    localparam op_t OP_WAKE      = 3'd4;

    // Result kinds
    localparam kind_t KIND_DISPATCH = 2'd0;
    localparam kind_t KIND_IDLE     = 2'd1;
    localparam kind_t KIND_PREEMPT  = 2'd2;
    localparam kind_t KIND_UPDATE   = 2'd3;

    // Process states
    localparam pstate_t ST_READY      = 2'd0;
    localparam pstate_t ST_RUNNING    = 2'd1;
    localparam pstate_t ST_WAITING    = 2'd2;
    localparam pstate_t ST_TERMINATED = 2'd3;

    // Scheduling modes
    localparam mode_t MODE_FIFO = 2'd0;
    localparam mode_t MODE_RR   = 2'd1;
    localparam mode_t MODE_PRIO = 2'd2;

    // Configuration register indexes
    localparam reg_idx_t REG_SCHED_MODE   = 2'd0;
    localparam reg_idx_t REG_SLICE_LENGTH = 2'd1;
    localparam reg_idx_t REG_ACTIVE_CPUS  = 2'd2;

    // Controller to datapath commands
    typedef struct packed {
        logic  ev_load;
        logic  ovf_load;
        logic  ovf_val;
        logic  dcpu_ev;
        logic  dcpu_wait;
        logic  push_run;
        logic  push_wake;
        logic  clr_busy;
        logic  set_wait;
        logic  scan_init;
        logic  scan_step;
        logic  scanning;
        logic  rd_head;
        logic  emit;
        kind_t emit_kind;
        logic  emit_last;
        logic  disp_commit;
    } cmd_t;

    // Datapath to controller status
    typedef struct packed {
        op_t   op;
        logic  cpu_ok;
        logic  busy_ev;
        logic  ring_empty;
        logic  ring_full;
        mode_t mode;
        logic  wait_any;
        logic  scan_done;
        logic  scan_busy;
        logic  found;
        logic  out_free;
    } stat_t;

endpackage

[rtl/core/mcrqs_ifs.sv]
// Event channel
interface mcrqs_req_if;
    logic                           valid;
    logic                           ready;
    logic [mcrqs_pkg::OP_W-1:0]     operation;
    logic [mcrqs_pkg::CPU_IDX_W-1:0] cpu_index;
    logic [mcrqs_pkg::PID_W-1:0]    process_id;
    logic [mcrqs_pkg::PRI_W-1:0]    priority_req;

    modport source (output valid, operation, cpu_index, process_id, priority_req,
                    input ready);
    modport sink   (input valid, operation, cpu_index, process_id, priority_req,
                    output ready);
endinterface

// Result channel
interface mcrqs_rsp_if;
    logic                            valid;
    logic                            ready;
    logic [mcrqs_pkg::KIND_W-1:0]    result_kind;
    logic [mcrqs_pkg::CPU_IDX_W-1:0] target_cpu;
    logic [mcrqs_pkg::PID_W-1:0]     target_process;
    logic [mcrqs_pkg::STATE_W-1:0]   new_state;
    logic [mcrqs_pkg::SLICE_W-1:0]   slice_out;
    logic                            queue_overflow;
    logic                            last_result;

    modport source (output valid, result_kind, target_cpu, target_process, new_state,
                    slice_out, queue_overflow, last_result, input ready);
    modport sink   (input valid, result_kind, target_cpu, target_process, new_state,
                    slice_out, queue_overflow, last_result, output ready);
endinterface

// Configuration write channel
interface mcrqs_cfg_if;
    logic                            valid;
    logic                            ready;
    logic [mcrqs_pkg::CFG_IDX_W-1:0] index;
    logic [mcrqs_pkg::CFG_DAT_W-1:0] data;

    modport source (output valid, index, data, input ready);
    modport sink   (input valid, index, data, output ready);
endinterface

[rtl/core/mcrqs_ram.sv]
module mcrqs_ram #(
    parameter int WIDTH = 14,
    parameter int DEPTH = 64,
    localparam int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              wr_en,
    input  logic [ADDR_W-1:0] wr_addr,
    input  logic [WIDTH-1:0]  wr_data,
    input  logic              rd_en,
    input  logic [ADDR_W-1:0] rd_addr,
    output logic [WIDTH-1:0]  rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    // Write port
    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
    end

    // Registered read port
    always_ff @(posedge clk)
    begin
        if (rd_en)
        begin
            rd_data <= mem[rd_addr];
        end
    end

endmodule

[rtl/core/mcrqs_ctrl.sv]
module mcrqs_ctrl (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              in_valid,
    output logic              in_ready,
    input  mcrqs_pkg::stat_t  stat,
    output mcrqs_pkg::cmd_t   cmd
);

    typedef enum logic [8:0] {
        S_IDLE   = 9'b000000001,
        S_DECODE = 9'b000000010,
        S_UPD    = 9'b000000100,
        S_SCAN   = 9'b000001000,
        S_FPRE   = 9'b000010000,
        S_PUSHW  = 9'b000100000,
        S_UPDW   = 9'b001000000,
        S_RD     = 9'b010000000,
        S_DISP   = 9'b100000000
    } state_t;

    state_t state_reg;
    state_t state_next;
    logic   ev_valid;

    // Events that produce work: wake-up always, others only on a known CPU
    assign ev_valid = (stat.op == mcrqs_pkg::OP_WAKE) ||
                      (((stat.op == mcrqs_pkg::OP_PREEMPT) ||
                        (stat.op == mcrqs_pkg::OP_YIELD) ||
                        (stat.op == mcrqs_pkg::OP_TERMINATE) ||
                        (stat.op == mcrqs_pkg::OP_IDLE)) && stat.cpu_ok);

    assign in_ready = (state_reg == S_IDLE);

    // Sequence the event
    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (in_valid)
                begin
                    cmd.ev_load = 1'b1;
                    state_next  = S_DECODE;
                end
            end
            S_DECODE:
            begin
                if (!ev_valid)
                begin
                    state_next = S_IDLE;
                end
                else
                begin
                    cmd.ovf_load = 1'b1;
                    unique case (stat.op) inside
                        mcrqs_pkg::OP_PREEMPT:
                        begin
                            cmd.ovf_val  = stat.busy_ev && stat.ring_full;
                            cmd.push_run = stat.busy_ev;
                            cmd.dcpu_ev  = 1'b1;
                            state_next   = S_RD;
                        end
                        mcrqs_pkg::OP_YIELD, mcrqs_pkg::OP_TERMINATE:
                        begin
                            cmd.dcpu_ev = 1'b1;
                            state_next  = stat.busy_ev ? S_UPD : S_RD;
                        end
                        mcrqs_pkg::OP_IDLE:
                        begin
                            cmd.dcpu_ev  = 1'b1;
                            cmd.clr_busy = 1'b1;
                            if (stat.ring_empty)
                            begin
                                cmd.set_wait = 1'b1;
                                state_next   = S_IDLE;
                            end
                            else
                            begin
                                state_next = S_RD;
                            end
                        end
                        mcrqs_pkg::OP_WAKE:
                        begin
                            cmd.ovf_val = stat.ring_full;
                            if (stat.mode == mcrqs_pkg::MODE_PRIO)
                            begin
                                cmd.scan_init = 1'b1;
                                state_next    = S_SCAN;
                            end
                            else
                            begin
                                state_next = S_PUSHW;
                            end
                        end
                        default:
                        begin
                            state_next = S_IDLE;
                        end
                    endcase
                end
            end
            S_UPD:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = mcrqs_pkg::KIND_UPDATE;
                    state_next    = S_RD;
                end
            end
            S_SCAN:
            begin
                cmd.scanning = 1'b1;
                if (stat.scan_done)
                begin
                    state_next = stat.found ? S_FPRE : S_PUSHW;
                end
                else if (!stat.scan_busy)
                begin
                    state_next = S_PUSHW;
                end
                else
                begin
                    cmd.scan_step = 1'b1;
                end
            end
            S_FPRE:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = mcrqs_pkg::KIND_PREEMPT;
                    state_next    = S_PUSHW;
                end
            end
            S_PUSHW:
            begin
                cmd.push_wake = 1'b1;
                cmd.dcpu_wait = 1'b1;
                state_next    = S_UPDW;
            end
            S_UPDW:
            begin
                if (stat.out_free)
                begin
                    cmd.emit      = 1'b1;
                    cmd.emit_kind = mcrqs_pkg::KIND_UPDATE;
                    cmd.emit_last = !stat.wait_any;
                    state_next    = stat.wait_any ? S_RD : S_IDLE;
                end
            end
            S_RD:
            begin
                cmd.rd_head = 1'b1;
                state_next  = S_DISP;
            end
            S_DISP:
            begin
                if (stat.out_free)
                begin
                    cmd.emit        = 1'b1;
                    cmd.emit_kind   = stat.ring_empty ? mcrqs_pkg::KIND_IDLE
                                                      : mcrqs_pkg::KIND_DISPATCH;
                    cmd.emit_last   = 1'b1;
                    cmd.disp_commit = 1'b1;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // State register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

[rtl/core/mcrqs_dpath.sv]
`include "assert_macros.svh"

module mcrqs_dpath #(
    parameter int MAX_CPUS    = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic                             clk,
    input  logic                             rst_n,
    input  mcrqs_pkg::cmd_t                  cmd,
    output mcrqs_pkg::stat_t                 stat,
    // event payload
    input  logic [mcrqs_pkg::OP_W-1:0]       in_operation,
    input  logic [mcrqs_pkg::CPU_IDX_W-1:0]  in_cpu_index,
    input  logic [mcrqs_pkg::PID_W-1:0]      in_process_id,
    input  logic [mcrqs_pkg::PRI_W-1:0]      in_priority_req,
    // configuration writes
    input  logic                             cfg_write,
    input  logic [mcrqs_pkg::CFG_IDX_W-1:0]  cfg_index,
    input  logic [mcrqs_pkg::CFG_DAT_W-1:0]  cfg_data,
    // result register
    output logic                             res_valid,
    input  logic                             res_ready,
    output logic [mcrqs_pkg::KIND_W-1:0]     res_kind,
    output logic [mcrqs_pkg::CPU_IDX_W-1:0]  res_cpu,
    output logic [mcrqs_pkg::PID_W-1:0]      res_process,
    output logic [mcrqs_pkg::STATE_W-1:0]    res_state,
    output logic [mcrqs_pkg::SLICE_W-1:0]    res_slice,
    output logic                             res_overflow,
    output logic                             res_last
);

    localparam int CPU_W  = (MAX_CPUS > 1) ? $clog2(MAX_CPUS) : 1;
    localparam int SCNT_W = $clog2(MAX_CPUS + 1);
    localparam int PTR_W  = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W  = $clog2(QUEUE_DEPTH + 1);
    localparam int CMP_W  = 8;
    localparam int PID_W  = mcrqs_pkg::PID_W;
    localparam int PRI_W  = mcrqs_pkg::PRI_W;

    // configuration
    mcrqs_pkg::mode_t                 mode_reg;
    logic [mcrqs_pkg::SLICE_W-1:0]    slice_reg;
    logic [mcrqs_pkg::ACT_W-1:0]      active_reg;

    // captured event
    mcrqs_pkg::op_t                   ev_op_reg;
    logic [mcrqs_pkg::CPU_IDX_W-1:0]  ev_cpu_reg;
    logic [PID_W-1:0]                 ev_pid_reg;
    logic [PRI_W-1:0]                 ev_pri_reg;
    logic                             ovf_reg;
    logic [CPU_W-1:0]                 dcpu_reg;
    logic [CPU_W-1:0]                 ev_idx;

    // ready ring
    logic [PTR_W-1:0]                 head_reg, head_next;
    logic [PTR_W-1:0]                 tail_reg, tail_next;
    logic [CNT_W-1:0]                 count_reg, count_next;
    logic                             ring_empty, ring_full;
    logic                             push_req, push_en, pop_en;
    logic [mcrqs_pkg::ENTRY_W-1:0]    wr_entry, rd_entry;
    logic [PID_W-1:0]                 rd_pid;
    logic [PRI_W-1:0]                 rd_pri;

    // per-CPU table
    logic [MAX_CPUS-1:0]              busy_reg, busy_next;
    logic [MAX_CPUS-1:0]              wait_reg, wait_next;
    logic [PID_W-1:0]                 run_pid_reg [MAX_CPUS];
    logic [PRI_W-1:0]                 run_pri_reg [MAX_CPUS];
    logic [CPU_W-1:0]                 tbl_idx;
    logic [PID_W-1:0]                 run_pid_rd;
    logic [PRI_W-1:0]                 run_pri_rd;
    logic                             busy_rd;
    logic [MAX_CPUS-1:0]              wait_onehot;
    logic [CPU_W-1:0]                 wait_first;

    // priority scan
    logic [SCNT_W-1:0]                scan_i_reg;
    logic [PRI_W-1:0]                 low_pri_reg;
    logic [CPU_W-1:0]                 low_id_reg;
    logic [PID_W-1:0]                 low_pid_reg;
    logic                             found_reg;
    logic                             scan_lower;

    // result register
    logic                             out_valid_reg, out_valid_next;
    mcrqs_pkg::kind_t                 out_kind_reg;
    logic [mcrqs_pkg::CPU_IDX_W-1:0]  out_cpu_reg, out_cpu_next;
    logic [PID_W-1:0]                 out_pid_reg, out_pid_next;
    mcrqs_pkg::pstate_t               out_state_reg, out_state_next;
    logic [mcrqs_pkg::SLICE_W-1:0]    out_slice_reg, out_slice_next;
    logic                             out_ovf_reg;
    logic                             out_last_reg;
    logic [mcrqs_pkg::SLICE_W-1:0]    slice_now;

    assign ev_idx = CPU_W'(ev_cpu_reg);

    // Ring status and access
    assign ring_empty = (count_reg == '0);
    assign ring_full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign push_req   = cmd.push_run || cmd.push_wake;
    assign push_en    = push_req && !ring_full;
    assign pop_en     = cmd.disp_commit && !ring_empty;
    assign wr_entry   = cmd.push_run ? {run_pid_rd, run_pri_rd} : {ev_pid_reg, ev_pri_reg};
    assign rd_pid     = rd_entry[mcrqs_pkg::ENTRY_W-1:PRI_W];
    assign rd_pri     = rd_entry[PRI_W-1:0];

    mcrqs_ram #(
        .WIDTH (mcrqs_pkg::ENTRY_W),
        .DEPTH (QUEUE_DEPTH)
    ) u_ring (
        .clk     (clk),
        .wr_en   (push_en),
        .wr_addr (tail_reg),
        .wr_data (wr_entry),
        .rd_en   (cmd.rd_head),
        .rd_addr (head_reg),
        .rd_data (rd_entry)
    );

    // Advance ring pointers
    always_comb
    begin
        head_next  = head_reg;
        tail_next  = tail_reg;
        count_next = count_reg;
        if (push_en)
        begin
            tail_next  = (tail_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : tail_reg + 1'b1;
            count_next = count_reg + 1'b1;
        end
        else if (pop_en)
        begin
            head_next  = (head_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : head_reg + 1'b1;
            count_next = count_reg - 1'b1;
        end
    end

    // Table read port: scan index while scanning, else the event CPU
    assign tbl_idx    = cmd.scanning ? scan_i_reg[CPU_W-1:0] : ev_idx;
    assign run_pid_rd = run_pid_reg[tbl_idx];
    assign run_pri_rd = run_pri_reg[tbl_idx];
    assign busy_rd    = busy_reg[tbl_idx];
    assign scan_lower = (run_pri_rd < low_pri_reg);

    // Pick the lowest-numbered waiting CPU
    assign wait_onehot = wait_reg & (~wait_reg + 1'b1);
    always_comb
    begin
        wait_first = '0;
        for (int i = 0; i < MAX_CPUS; i++)
        begin
            if (wait_onehot[i])
            begin
                wait_first = wait_first | CPU_W'(i);
            end
        end
    end

    // Update busy and waiting bits
    always_comb
    begin
        busy_next = busy_reg;
        wait_next = wait_reg;
        if (cmd.clr_busy)
        begin
            busy_next[ev_idx] = 1'b0;
        end
        if (cmd.set_wait)
        begin
            wait_next[ev_idx] = 1'b1;
        end
        if (cmd.disp_commit)
        begin
            busy_next[dcpu_reg] = !ring_empty;
            wait_next[dcpu_reg] = 1'b0;
        end
    end

    // Build the next result beat
    assign slice_now = (mode_reg == mcrqs_pkg::MODE_RR) ? slice_reg : '0;
    always_comb
    begin
        unique case (cmd.emit_kind)
            mcrqs_pkg::KIND_DISPATCH:
            begin
                out_cpu_next   = mcrqs_pkg::CPU_IDX_W'(dcpu_reg);
                out_pid_next   = rd_pid;
                out_state_next = mcrqs_pkg::ST_RUNNING;
                out_slice_next = slice_now;
            end
            mcrqs_pkg::KIND_IDLE:
            begin
                out_cpu_next   = mcrqs_pkg::CPU_IDX_W'(dcpu_reg);
                out_pid_next   = '0;
                out_state_next = mcrqs_pkg::ST_READY;
                out_slice_next = slice_now;
            end
            mcrqs_pkg::KIND_PREEMPT:
            begin
                out_cpu_next   = mcrqs_pkg::CPU_IDX_W'(low_id_reg);
                out_pid_next   = low_pid_reg;
                out_state_next = mcrqs_pkg::ST_READY;
                out_slice_next = '0;
            end
            mcrqs_pkg::KIND_UPDATE:
            begin
                out_slice_next = '0;
                if (ev_op_reg == mcrqs_pkg::OP_WAKE)
                begin
                    out_cpu_next   = '0;
                    out_pid_next   = ev_pid_reg;
                    out_state_next = mcrqs_pkg::ST_READY;
                end
                else
                begin
                    out_cpu_next   = ev_cpu_reg;
                    out_pid_next   = run_pid_rd;
                    out_state_next = (ev_op_reg == mcrqs_pkg::OP_YIELD) ?
                                     mcrqs_pkg::ST_WAITING : mcrqs_pkg::ST_TERMINATED;
                end
            end
        endcase
    end

    // Hold the result until taken
    assign out_valid_next = cmd.emit ? 1'b1 : (res_ready ? 1'b0 : out_valid_reg);

    // Control registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg      <= mcrqs_pkg::MODE_FIFO;
            slice_reg     <= '0;
            active_reg    <= mcrqs_pkg::ACT_W'(1);
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            busy_reg      <= '0;
            wait_reg      <= '0;
            found_reg     <= 1'b0;
            scan_i_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            if (cfg_write)
            begin
                unique case (cfg_index)
                    mcrqs_pkg::REG_SCHED_MODE:   mode_reg   <= cfg_data[mcrqs_pkg::MODE_W-1:0];
                    mcrqs_pkg::REG_SLICE_LENGTH: slice_reg  <= cfg_data;
                    mcrqs_pkg::REG_ACTIVE_CPUS:  active_reg <= cfg_data[mcrqs_pkg::ACT_W-1:0];
                    default:                     ;
                endcase
            end
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            busy_reg      <= busy_next;
            wait_reg      <= wait_next;
            out_valid_reg <= out_valid_next;
            if (cmd.scan_init)
            begin
                scan_i_reg <= '0;
                found_reg  <= 1'b0;
            end
            else if (cmd.scan_step)
            begin
                scan_i_reg <= scan_i_reg + 1'b1;
                if (scan_lower)
                begin
                    found_reg <= 1'b1;
                end
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        if (cmd.ev_load)
        begin
            ev_op_reg  <= in_operation;
            ev_cpu_reg <= in_cpu_index;
            ev_pid_reg <= in_process_id;
            ev_pri_reg <= in_priority_req;
        end
        if (cmd.ovf_load)
        begin
            ovf_reg <= cmd.ovf_val;
        end
        if (cmd.dcpu_ev)
        begin
            dcpu_reg <= ev_idx;
        end
        else if (cmd.dcpu_wait)
        begin
            dcpu_reg <= wait_first;
        end
        if (pop_en)
        begin
            run_pid_reg[dcpu_reg] <= rd_pid;
            run_pri_reg[dcpu_reg] <= rd_pri;
        end
        if (cmd.scan_init)
        begin
            low_pri_reg <= ev_pri_reg;
        end
        else if (cmd.scan_step && scan_lower)
        begin
            low_pri_reg <= run_pri_rd;
            low_id_reg  <= scan_i_reg[CPU_W-1:0];
            low_pid_reg <= run_pid_rd;
        end
        if (cmd.emit)
        begin
            out_kind_reg  <= cmd.emit_kind;
            out_cpu_reg   <= out_cpu_next;
            out_pid_reg   <= out_pid_next;
            out_state_reg <= out_state_next;
            out_slice_reg <= out_slice_next;
            out_ovf_reg   <= ovf_reg;
            out_last_reg  <= cmd.emit_last;
        end
    end

    // Status to the controller
    assign stat.op         = ev_op_reg;
    assign stat.cpu_ok     = (CMP_W'(ev_cpu_reg) < CMP_W'(MAX_CPUS));
    assign stat.busy_ev    = busy_rd;
    assign stat.ring_empty = ring_empty;
    assign stat.ring_full  = ring_full;
    assign stat.mode       = mode_reg;
    assign stat.wait_any   = |wait_reg;
    assign stat.scan_done  = (CMP_W'(scan_i_reg) >= CMP_W'(active_reg)) ||
                             (scan_i_reg == SCNT_W'(MAX_CPUS));
    assign stat.scan_busy  = busy_rd;
    assign stat.found      = found_reg;
    assign stat.out_free   = !out_valid_reg || res_ready;

    assign res_valid    = out_valid_reg;
    assign res_kind     = out_kind_reg;
    assign res_cpu      = out_cpu_reg;
    assign res_process  = out_pid_reg;
    assign res_state    = out_state_reg;
    assign res_slice    = out_slice_reg;
    assign res_overflow = out_ovf_reg;
    assign res_last     = out_last_reg;

    // Ring and table invariants
    `ASSERT_HOLDS(a_count_bound, clk, rst_n, count_reg <= CNT_W'(QUEUE_DEPTH))
    `ASSERT_IMPLY(a_empty_ptrs, clk, rst_n, count_reg == '0, head_reg == tail_reg)
    `ASSERT_HOLDS(a_busy_wait_excl, clk, rst_n, (busy_reg & wait_reg) == '0)
    `ASSERT_NEXT(a_push_count, clk, rst_n, push_en, count_reg == $past(count_reg) + 1'b1)

endmodule

[rtl/core/multi_cpu_ready_queue_scheduler_unit.sv]
// Ready-queue CPU scheduler. Events (preempt, yield, terminate, idle request,
// wake-up) enter on the request channel one at a time; each yields zero to three
// result beats on the response channel, the final one marked by last_result.
// Sequence between accepted events: a decode step, then a return to idle to take the
// next; a dispatch adds a read step and a dispatch step because the ready ring sits
// in a RAM with a registered read; a state update, a forced-preempt request or a
// wake-up's enqueue adds a step each; in priority mode a wake-up scans the CPU table
// one CPU per cycle, up to min(active_cpus, MAX_CPUS) CPUs, stopping at the first
// idle CPU. Any step that emits a beat waits while the response side stalls. The
// next event is taken once the final beat of the current one sits in the output
// register. Configuration writes are taken every cycle and must be issued only while
// no event is active.
module multi_cpu_ready_queue_scheduler_unit #(
    parameter int MAX_CPUS    = 16,
    parameter int QUEUE_DEPTH = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    mcrqs_req_if.sink    request,
    mcrqs_rsp_if.source  response,
    mcrqs_cfg_if.sink    cfg
);

    mcrqs_pkg::cmd_t  cmd;
    mcrqs_pkg::stat_t stat;

    // Configuration channel never stalls
    assign cfg.ready = 1'b1;

    mcrqs_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (request.valid),
        .in_ready (request.ready),
        .stat     (stat),
        .cmd      (cmd)
    );

    mcrqs_dpath #(
        .MAX_CPUS    (MAX_CPUS),
        .QUEUE_DEPTH (QUEUE_DEPTH)
    ) u_dpath (
        .clk             (clk),
        .rst_n           (rst_n),
        .cmd             (cmd),
        .stat            (stat),
        .in_operation    (request.operation),
        .in_cpu_index    (request.cpu_index),
        .in_process_id   (request.process_id),
        .in_priority_req (request.priority_req),
        .cfg_write       (cfg.valid),
        .cfg_index       (cfg.index),
        .cfg_data        (cfg.data),
        .res_valid       (response.valid),
        .res_ready       (response.ready),
        .res_kind        (response.result_kind),
        .res_cpu         (response.target_cpu),
        .res_process     (response.target_process),
        .res_state       (response.new_state),
        .res_slice       (response.slice_out),
        .res_overflow    (response.queue_overflow),
        .res_last        (response.last_result)
    );

endmodule

[dv/sched_event_checker.sv]
// Watches the event, result and register-write channels of the scheduler,
// keeps its own copy of the ready ring and the CPU table, and compares every
// result beat with the oldest predicted one.
module sched_event_checker
    import mcrqs_pkg::*;
#(
    parameter int NCPU   = 16,
    parameter int QDEPTH = 64
) (
    input  logic        clk,
    input  logic        rst_n,
    mcrqs_req_if        request,
    mcrqs_rsp_if        response,
    mcrqs_cfg_if        cfg,
    output int          mismatches,
    output int          pending
);

    typedef struct packed {
        kind_t                kind;
        logic [CPU_IDX_W-1:0] cpu;
        logic [PID_W-1:0]     pid;
        pstate_t              st;
        logic [SLICE_W-1:0]   slice;
        logic                 ovf;
        logic                 last;
    } sched_beat_t;

    // Shadow registers
    mode_t              sched_mode_q;
    logic [SLICE_W-1:0] slice_q;
    logic [ACT_W-1:0]   active_q;

    // Shadow ready ring and CPU table
    logic [PID_W-1:0]   ring_pid [QDEPTH];
    logic [PRI_W-1:0]   ring_pri [QDEPTH];
    int unsigned        ring_head;
    int unsigned        ring_tail;
    int unsigned        ring_count;
    logic [PID_W-1:0]   run_pid [NCPU];
    logic [PRI_W-1:0]   run_pri [NCPU];
    logic               busy [NCPU];
    logic               waiting [NCPU];

    sched_beat_t        event_beats[$];
    sched_beat_t        expected_beats[$];

    function automatic void clear_model();
        sched_mode_q = MODE_FIFO;
        slice_q      = '0;
        active_q     = 5'd1;
        ring_head    = 0;
        ring_tail    = 0;
        ring_count   = 0;
        for (int i = 0; i < NCPU; i++)
        begin
            run_pid[i] = '0;
            run_pri[i] = '0;
            busy[i]    = 1'b0;
            waiting[i] = 1'b0;
        end
        expected_beats.delete();
    endfunction

    function automatic void add_beat(kind_t k, int c, logic [PID_W-1:0] p, pstate_t s,
                                     logic [SLICE_W-1:0] sl);
        sched_beat_t b;
        b.kind  = k;
        b.cpu   = c[CPU_IDX_W-1:0];
        b.pid   = p;
        b.st    = s;
        b.slice = sl;
        b.ovf   = 1'b0;
        b.last  = 1'b0;
        event_beats.push_back(b);
    endfunction

    function automatic logic [SLICE_W-1:0] slice_now();
        return (sched_mode_q == MODE_RR) ? slice_q : '0;
    endfunction

    // Append at the tail; drop when the ring is full
    function automatic bit push_ready(logic [PID_W-1:0] p, logic [PRI_W-1:0] r);
        if (ring_count >= QDEPTH)
            return 1'b0;
        ring_pid[ring_tail] = p;
        ring_pri[ring_tail] = r;
        ring_tail = (ring_tail + 1) % QDEPTH;
        ring_count++;
        return 1'b1;
    endfunction

    // Hand the ring head to a CPU, or the idle process when the ring is empty
    function automatic void dispatch_to(int c);
        waiting[c] = 1'b0;
        if (ring_count > 0)
        begin
            run_pid[c] = ring_pid[ring_head];
            run_pri[c] = ring_pri[ring_head];
            ring_head  = (ring_head + 1) % QDEPTH;
            ring_count--;
            busy[c] = 1'b1;
            add_beat(KIND_DISPATCH, c, run_pid[c], ST_RUNNING, slice_now());
        end
        else
        begin
            busy[c]    = 1'b0;
            run_pid[c] = '0;
            run_pri[c] = '0;
            add_beat(KIND_IDLE, c, '0, ST_READY, slice_now());
        end
    endfunction

    function automatic void predict_event(op_t op, logic [CPU_IDX_W-1:0] cpu,
                                          logic [PID_W-1:0] pid, logic [PRI_W-1:0] pri);
        bit               ovf;
        bit               found;
        bit               idle_seen;
        int               scan;
        int               low_id;
        logic [PRI_W-1:0] low_pri;
        ovf = 1'b0;
        event_beats.delete();
        if (op <= OP_IDLE && cpu >= NCPU)
            return;
        case (op)
            OP_PREEMPT:
            begin
                if (busy[cpu])
                    ovf = !push_ready(run_pid[cpu], run_pri[cpu]);
                dispatch_to(int'(cpu));
            end
            OP_YIELD, OP_TERMINATE:
            begin
                if (busy[cpu])
                    add_beat(KIND_UPDATE, int'(cpu), run_pid[cpu],
                             (op == OP_YIELD) ? ST_WAITING : ST_TERMINATED, '0);
                dispatch_to(int'(cpu));
            end
            OP_IDLE:
            begin
                busy[cpu]    = 1'b0;
                run_pid[cpu] = '0;
                run_pri[cpu] = '0;
                if (ring_count > 0)
                    dispatch_to(int'(cpu));
                else
                    waiting[cpu] = 1'b1;
            end
            OP_WAKE:
            begin
                // Priority mode: ask the weakest scanned CPU to step aside when none scanned is idle
                if (sched_mode_q == MODE_PRIO)
                begin
                    scan      = (int'(active_q) < NCPU) ? int'(active_q) : NCPU;
                    low_pri   = pri;
                    low_id    = 0;
                    found     = 1'b0;
                    idle_seen = 1'b0;
                    for (int i = 0; i < scan; i++)
                    begin
                        if (!busy[i])
                        begin
                            idle_seen = 1'b1;
                            break;
                        end
                        if (run_pri[i] < low_pri)
                        begin
                            low_pri = run_pri[i];
                            low_id  = i;
                            found   = 1'b1;
                        end
                    end
                    if (!idle_seen && found)
                        add_beat(KIND_PREEMPT, low_id, run_pid[low_id], ST_READY, '0);
                end
                ovf = !push_ready(pid, pri);
                add_beat(KIND_UPDATE, 0, pid, ST_READY, '0);
                // First waiting CPU takes the head
                for (int i = 0; i < NCPU; i++)
                begin
                    if (waiting[i])
                    begin
                        if (ring_count > 0)
                            dispatch_to(i);
                        break;
                    end
                end
            end
            default: ;
        endcase
        foreach (event_beats[k])
        begin
            event_beats[k].ovf  = ovf;
            event_beats[k].last = (k == event_beats.size() - 1);
            expected_beats.push_back(event_beats[k]);
        end
    endfunction

    function automatic void compare_field(string name, logic [SLICE_W-1:0] want,
                                          logic [SLICE_W-1:0] got);
        if (got !== want)
        begin
            $error("%s: expected %0d, got %0d", name, want, got);
            mismatches++;
        end
    endfunction

    // Track register writes, predict on every event beat, check every result beat
    always @(posedge clk)
    begin
        sched_beat_t want;
        if (!rst_n)
            clear_model();
        else
        begin
            if (cfg.valid && cfg.ready)
            begin
                case (cfg.index)
                    REG_SCHED_MODE:   sched_mode_q = cfg.data[MODE_W-1:0];
                    REG_SLICE_LENGTH: slice_q      = cfg.data[SLICE_W-1:0];
                    REG_ACTIVE_CPUS:  active_q     = cfg.data[ACT_W-1:0];
                    default: ;
                endcase
            end
            if (request.valid && request.ready)
                predict_event(request.operation, request.cpu_index, request.process_id,
                              request.priority_req);
            if (response.valid && response.ready)
            begin
                if (expected_beats.size() == 0)
                begin
                    $error("result beat with nothing expected: kind %0d cpu %0d process %0d",
                           response.result_kind, response.target_cpu,
                           response.target_process);
                    mismatches++;
                end
                else
                begin
                    want = expected_beats.pop_front();
                    compare_field("result_kind", SLICE_W'(want.kind),
                                  SLICE_W'(response.result_kind));
                    compare_field("target_cpu", SLICE_W'(want.cpu),
                                  SLICE_W'(response.target_cpu));
                    compare_field("target_process", SLICE_W'(want.pid),
                                  SLICE_W'(response.target_process));
                    compare_field("new_state", SLICE_W'(want.st),
                                  SLICE_W'(response.new_state));
                    compare_field("slice_out", want.slice, response.slice_out);
                    compare_field("queue_overflow", SLICE_W'(want.ovf),
                                  SLICE_W'(response.queue_overflow));
                    compare_field("last_result", SLICE_W'(want.last),
                                  SLICE_W'(response.last_result));
                end
            end
        end
        pending = expected_beats.size();
    end

endmodule

[dv/testbench.sv]
module testbench;
    import mcrqs_pkg::*;

    localparam int NUM_CPUS     = 16;
    localparam int RING_DEPTH   = 64;
    localparam int HOLD_CYCLES  = 200;
    localparam int DRAIN_CYCLES = 50;

    // Mode code the block treats as fifo
    localparam mode_t MODE_SPARE = 2'd3;
    // Highest code the operation field can carry
    localparam op_t OP_TOP_CODE = '1;

    typedef enum {FLOW_OPEN, FLOW_COIN, FLOW_CHOKED, FLOW_TOGGLE} flow_t;

    logic clk = 1'b0;
    logic rst_n = 1'b0;
    int   mismatches;
    int   pending;
    int   burst_left = 0;
    int   hold_requests = 0;
    int   holds_served = 0;

    mcrqs_req_if request ();
    mcrqs_rsp_if response ();
    mcrqs_cfg_if cfg ();

    multi_cpu_ready_queue_scheduler_unit #(
        .MAX_CPUS    (NUM_CPUS),
        .QUEUE_DEPTH (RING_DEPTH)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .request  (request),
        .response (response),
        .cfg      (cfg)
    );

    sched_event_checker #(
        .NCPU   (NUM_CPUS),
        .QDEPTH (RING_DEPTH)
    ) event_checker (
        .clk        (clk),
        .rst_n      (rst_n),
        .request    (request),
        .response   (response),
        .cfg        (cfg),
        .mismatches (mismatches),
        .pending    (pending)
    );

    always
    begin
        #10 clk = 1'b1;
        #10 clk = 1'b0;
    end

    // Offer one event beat; open a new burst after a random gap when one runs out
    task automatic send_event(op_t op, logic [CPU_IDX_W-1:0] cpu, logic [PID_W-1:0] pid,
                              logic [PRI_W-1:0] pri);
        int gap;
        if (burst_left == 0)
        begin
            gap = $urandom_range(0, 6);
            if (gap != 0)
            begin
                request.valid <= 1'b0;
                repeat (gap) @(posedge clk);
            end
            burst_left = $urandom_range(1, 12);
        end
        burst_left--;
        request.valid        <= 1'b1;
        request.operation    <= op;
        request.cpu_index    <= cpu;
        request.process_id   <= pid;
        request.priority_req <= pri;
        do @(posedge clk); while (!request.ready);
    endtask

    // Drop valid and wait for every expected beat plus the block's tail latency
    task automatic settle();
        request.valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(reg_idx_t idx, logic [CFG_DAT_W-1:0] val);
        cfg.valid <= 1'b1;
        cfg.index <= idx;
        cfg.data  <= val;
        do @(posedge clk); while (!cfg.ready);
    endtask

    task automatic configure(mode_t mode, logic [SLICE_W-1:0] slice, logic [ACT_W-1:0] active);
        settle();
        write_reg(REG_SCHED_MODE, CFG_DAT_W'(mode));
        write_reg(REG_SLICE_LENGTH, slice);
        write_reg(REG_ACTIVE_CPUS, CFG_DAT_W'(active));
        cfg.valid <= 1'b0;
    endtask

    // Hand-picked events under the reset settings, then a priority check
    task automatic run_directed();
        send_event(OP_YIELD, 4'd0, 6'd0, 8'd0);         // idle CPU, empty ring
        send_event(OP_IDLE, 4'd15, 6'd0, 8'd0);         // CPU 15 starts waiting
        send_event(OP_WAKE, 4'd0, 6'd63, 8'hFF);        // goes straight to CPU 15
        send_event(OP_WAKE, 4'd7, 6'd0, 8'h00);
        send_event(OP_WAKE, 4'd9, 6'd42, 8'h80);
        send_event(OP_PREEMPT, 4'd15, 6'd0, 8'd0);      // requeue 63, run 0
        send_event(OP_YIELD, 4'd15, 6'd0, 8'd0);
        send_event(OP_TERMINATE, 4'd15, 6'd0, 8'd0);
        send_event(OP_TERMINATE, 4'd15, 6'd0, 8'd0);    // ring now empty
        send_event(OP_PREEMPT, 4'd3, 6'd0, 8'd0);       // preempt of an idle CPU
        send_event(OP_IDLE, 4'd0, 6'd0, 8'd0);
        send_event(OP_WAKE + 3'd1, 4'd2, 6'd5, 8'd5);   // unknown codes, ignored
        send_event(OP_WAKE + 3'd2, 4'd15, 6'd63, 8'hFF);
        send_event(OP_TOP_CODE, 4'd0, 6'd0, 8'd0);
        send_event(OP_WAKE, 4'd0, 6'd21, 8'h55);        // to waiting CPU 0
        send_event(OP_IDLE, 4'd0, 6'd0, 8'd0);          // busy CPU goes idle
        send_event(OP_WAKE, 4'd0, 6'd7, 8'hAA);
        send_event(OP_WAKE, 4'd0, 6'd1, 8'h10);
        send_event(OP_WAKE, 4'd0, 6'd2, 8'h20);
        send_event(OP_IDLE, 4'd0, 6'd0, 8'd0);          // idle with a queued head
        configure(MODE_PRIO, 16'hFFFF, 5'd1);
        send_event(OP_WAKE, 4'd0, 6'd5, 8'h00);         // not strictly higher
        send_event(OP_WAKE, 4'd0, 6'd6, 8'hFF);         // forces a preempt request
        send_event(OP_YIELD, 4'd0, 6'd0, 8'd0);
    endtask

    // Random events under one register setting
    task automatic run_phase(mode_t mode, logic [SLICE_W-1:0] slice, logic [ACT_W-1:0] active,
                             int items, int wake_pct, int cpu_span, bit squeeze);
        int               taken;
        op_t              op;
        logic [PRI_W-1:0] pri;
        configure(mode, slice, active);
        if (squeeze)
            hold_requests++;
        taken = 0;
        while (taken < items)
        begin
            if ($urandom_range(0, 99) < 3)
                op = op_t'($urandom_range(OP_WAKE + 1, OP_TOP_CODE));
            else if ($urandom_range(0, 99) < wake_pct)
                op = OP_WAKE;
            else
                op = op_t'($urandom_range(OP_PREEMPT, OP_IDLE));
            if ($urandom_range(0, 7) == 0)
                pri = $urandom_range(0, 1) ? 8'hFF : 8'h00;
            else
                pri = PRI_W'($urandom_range(0, 255));
            send_event(op, CPU_IDX_W'($urandom_range(0, cpu_span - 1)),
                       PID_W'($urandom_range(0, 63)), pri);
            if (op <= OP_WAKE)
                taken++;
        end
    endtask

    // Stimulus and verdict
    initial
    begin
        request.valid        <= 1'b0;
        request.operation    <= OP_PREEMPT;
        request.cpu_index    <= '0;
        request.process_id   <= '0;
        request.priority_req <= '0;
        cfg.valid            <= 1'b0;
        cfg.index            <= REG_SCHED_MODE;
        cfg.data             <= '0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        run_directed();
        run_phase(MODE_FIFO, SLICE_W'($urandom_range(0, 65535)), 5'd16, 50, 35, 16, 1'b1);
        run_phase(MODE_RR, 16'hFFFF, 5'd16, 100, 90, 16, 1'b0);     // fill past full
        run_phase(MODE_RR, 16'h0000, 5'd5, 60, 10, 16, 1'b0);       // drain
        run_phase(MODE_PRIO, SLICE_W'($urandom_range(0, 65535)), 5'd3, 50, 45, 4, 1'b0);
        run_phase(MODE_PRIO, SLICE_W'($urandom_range(0, 65535)), 5'd16, 40, 40, 16, 1'b0);
        run_phase(MODE_PRIO, SLICE_W'($urandom_range(0, 65535)), 5'd0, 25, 50, 16, 1'b0);
        run_phase(MODE_PRIO, SLICE_W'($urandom_range(0, 65535)), 5'd31, 25, 50, 16, 1'b0);
        run_phase(MODE_SPARE, SLICE_W'($urandom_range(0, 65535)), 5'd1, 25, 40, 16, 1'b0);
        settle();

        if (mismatches == 0 && pending == 0)
            $display("multi_cpu_ready_queue_scheduler_unit regression: pass");
        else
            $display("multi_cpu_ready_queue_scheduler_unit regression: fail");
        $finish;
    end

    // Result side: runs of open flow, coin flips, heavy stalls and toggling,
    // plus a long hold-off whenever one is requested
    initial
    begin
        flow_t style;
        int    run;
        response.ready <= 1'b0;
        forever
        begin
            style = flow_t'($urandom_range(0, 3));
            run   = $urandom_range(8, 60);
            repeat (run)
            begin
                @(posedge clk);
                if (holds_served != hold_requests)
                begin
                    response.ready <= 1'b0;
                    repeat (HOLD_CYCLES) @(posedge clk);
                    holds_served++;
                end
                else
                begin
                    case (style)
                        FLOW_OPEN:   response.ready <= 1'b1;
                        FLOW_COIN:   response.ready <= 1'($urandom_range(0, 1));
                        FLOW_CHOKED: response.ready <= ($urandom_range(0, 3) == 0);
                        default:     response.ready <= ~response.ready;
                    endcase
                end
            end
        end
    end

    // Watchdog
    initial
    begin
        #4000000;
        $display("multi_cpu_ready_queue_scheduler_unit regression: fail");
        $finish;
    end

endmodule

[sim.f]
+incdir+rtl/core
rtl/core/mcrqs_pkg.sv
rtl/core/mcrqs_ifs.sv
rtl/core/mcrqs_ram.sv
rtl/core/mcrqs_ctrl.sv
rtl/core/mcrqs_dpath.sv
rtl/core/multi_cpu_ready_queue_scheduler_unit.sv
dv/sched_event_checker.sv
dv/testbench.sv
